>>> hw/rtl/scma_pkg.sv
// Shared types and constants for the sensor code converter with moving average.
// Holds the beat structs, the front-to-back queue item and the divider interface.
// No dependencies.
`default_nettype none

package scma_pkg;

    localparam int unsigned WINDOW_LEN_DEF = 8;

    localparam int unsigned TEMP_CODE_W = 12;
    localparam int unsigned VREF_CODE_W = 12;
    localparam int unsigned TEMP_B_W    = 19;
    localparam int unsigned VDD_W       = 16;
    localparam int unsigned TEMP_Q8_W   = 20;
    localparam int unsigned RAIL_W      = 17;
    localparam int unsigned CUR_W       = 13;

    localparam logic [TEMP_B_W-1:0]    TEMP_BIAS     = 19'd71424;
    localparam logic [7:0]             TEMP_GAIN     = 8'd165;
    localparam logic [TEMP_CODE_W-1:0] TEMP_DIV_LOW  = 12'd4095;
    localparam logic [VDD_W-1:0]       VDD_MAX_MV    = 16'hFFFF;
    localparam logic [VREF_CODE_W-1:0] VREF_CLIP_MAX = 12'd74;

    localparam int unsigned DIV_DW             = 24;
    localparam int unsigned DIV_VW             = 13;
    localparam int unsigned DIV_BITS_PER_CYCLE = 2;
    localparam int unsigned DIV_STEPS          = DIV_DW / DIV_BITS_PER_CYCLE;
    localparam logic [DIV_DW-1:0] VDD_NUM2     = 24'd9828000;

    localparam logic [CUR_W-1:0] CUR_BASE_MA = 13'd100;
    localparam int unsigned      DIV10_MW    = 17;
    localparam logic [DIV10_MW-1:0] DIV10_M  = 17'd104858;
    localparam int unsigned      DIV10_SH    = 20;

    localparam int unsigned QDEPTH = 2;

    typedef struct packed {
        logic [TEMP_CODE_W-1:0] temp_code;
        logic [VREF_CODE_W-1:0] vref_code;
    } in_t;

    typedef struct packed {
        logic signed [TEMP_Q8_W-1:0] avg_temp_q8;
        logic [VDD_W-1:0]            avg_vdd_mv;
        logic [RAIL_W-1:0]           est_rail5_mv;
        logic [CUR_W-1:0]            est_current_ma;
        logic                        vdd_clipped;
    } out_t;

    typedef struct packed {
        logic [TEMP_B_W-1:0]    temp_b;
        logic [VREF_CODE_W-1:0] vref_code;
        logic                   clipped;
    } q_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VDD_W-1:0] quot;
    } div_resp_t;

endpackage

`default_nettype wire

>>> hw/rtl/scma_front.sv
// Front stage: takes input beats, converts the temperature code to biased 1/256 degC
// and classifies the reference code as saturating or not. Depends on scma_pkg.
`default_nettype none

module scma_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire scma_pkg::in_t     sample,
    input  wire logic              fifo_full,
    output logic                   wr_en,
    output scma_pkg::q_item_t      item
);

    logic                             hold_valid_reg;
    logic                             hold_valid_next;
    scma_pkg::in_t                    hold_reg;
    logic                             accept;
    logic [19:0]                      prod;
    logic [12:0]                      lo_sum;
    logic [7:0]                       quo;
    logic [19:0]                      rnd;

    assign full   = hold_valid_reg && fifo_full;
    assign accept = push && !full;
    assign wr_en  = hold_valid_reg && !fifo_full;

    always_comb
    begin
        hold_valid_next = accept || (hold_valid_reg && !wr_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= sample;
        end
    end

    // round(code * 337920 / 4095) = floor((x + 1 + floor(x / 4095)) / 2), x = 165 * code
    always_comb
    begin
        prod   = 20'(hold_reg.temp_code) * 20'(scma_pkg::TEMP_GAIN);
        lo_sum = 13'(prod[19:12]) + 13'(prod[11:0]);
        quo    = prod[19:12] + ((lo_sum >= 13'(scma_pkg::TEMP_DIV_LOW)) ? 8'd1 : 8'd0);
        rnd    = prod + 20'd1 + 20'(quo);
        item.temp_b    = rnd[19:1];
        item.vref_code = hold_reg.vref_code;
        item.clipped   = (hold_reg.vref_code <= scma_pkg::VREF_CLIP_MAX);
    end

endmodule

`default_nettype wire

>>> hw/rtl/scma_fifo.sv
// Short queue between front and back stages.
// Holds classified items; depends on scma_pkg.
`default_nettype none

module scma_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire scma_pkg::q_item_t wr_item,
    output logic                   full,
    input  wire logic              rd_en,
    output scma_pkg::q_item_t      rd_item,
    output logic                   empty
);

    localparam int unsigned AW = (scma_pkg::QDEPTH > 1) ? $clog2(scma_pkg::QDEPTH) : 1;
    localparam int unsigned CW = $clog2(scma_pkg::QDEPTH + 1);

    scma_pkg::q_item_t mem [scma_pkg::QDEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_wr;
    logic              do_rd;

    assign full    = (count_reg == CW'(scma_pkg::QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(scma_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(scma_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/scma_divider.sv
// Restoring divider, two quotient bits per cycle, for the supply conversion.
// Depends on scma_pkg for widths and the request and response structs.
`default_nettype none

module scma_divider (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire scma_pkg::div_req_t  req,
    output scma_pkg::div_resp_t      resp
);

    localparam int unsigned CNT_W = $clog2(scma_pkg::DIV_STEPS);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic [scma_pkg::DIV_VW-1:0]    rem_reg;
    logic [scma_pkg::DIV_DW-1:0]    dq_reg;
    logic [scma_pkg::DIV_VW-1:0]    den_reg;
    logic [scma_pkg::DIV_VW-1:0]    rem_c;
    logic [scma_pkg::DIV_DW-1:0]    dq_c;
    logic [scma_pkg::DIV_VW:0]      trial;

    always_comb
    begin
        rem_c = rem_reg;
        dq_c  = dq_reg;
        trial = '0;
        for (int i = 0; i < scma_pkg::DIV_BITS_PER_CYCLE; i++)
        begin
            trial = {rem_c, dq_c[scma_pkg::DIV_DW-1]};
            dq_c  = {dq_c[scma_pkg::DIV_DW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_c   = scma_pkg::DIV_VW'(trial - {1'b0, den_reg});
                dq_c[0] = 1'b1;
            end
            else
            begin
                rem_c = trial[scma_pkg::DIV_VW-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(scma_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dq_reg  <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_c;
            dq_reg  <= dq_c;
        end
    end

    assign resp.done = done_reg;
    assign resp.quot = dq_reg[scma_pkg::VDD_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/scma_back.sv
// Back stage: supply conversion, ring stores, running sums, windowed means and
// the output register. Depends on scma_pkg and scma_divider.
`default_nettype none

module scma_back #(
    parameter int unsigned WINDOW_LEN = scma_pkg::WINDOW_LEN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fifo_empty,
    input  wire scma_pkg::q_item_t fifo_head,
    output logic                   fifo_pop,
    input  wire logic              pop,
    output logic                   empty,
    output scma_pkg::out_t         result
);

    localparam int unsigned LG    = $clog2(WINDOW_LEN);
    localparam int unsigned SW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int unsigned TS_W  = scma_pkg::TEMP_B_W + LG;
    localparam int unsigned VS_W  = scma_pkg::VDD_W + LG;
    localparam int unsigned TK    = TS_W + LG;
    localparam int unsigned VK    = VS_W + LG;
    localparam int unsigned TP_W  = 2 * TS_W + 1;
    localparam int unsigned VP_W  = 2 * VS_W + 1;
    localparam int unsigned CP_W  = scma_pkg::VDD_W + scma_pkg::DIV10_MW;
    localparam logic [63:0] TM64  = ((64'd1 << TK) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [63:0] VM64  = ((64'd1 << VK) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [TS_W:0] TM  = TM64[TS_W:0];
    localparam logic [VS_W:0] VM  = VM64[VS_W:0];
    localparam logic [TS_W-1:0] TSUM_RST = TS_W'(WINDOW_LEN * 71424);
    localparam logic [VS_W-1:0] VSUM_MAX = VS_W'(WINDOW_LEN * 65535);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SCL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [SW-1:0]                    slot_reg;
    logic [SW-1:0]                    slot_next;
    logic [WINDOW_LEN-1:0]            valid_reg;
    logic [WINDOW_LEN-1:0]            valid_next;
    logic [TS_W-1:0]                  tsum_reg;
    logic [TS_W-1:0]                  tsum_next;
    logic [VS_W-1:0]                  vsum_reg;
    logic [VS_W-1:0]                  vsum_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    logic [scma_pkg::TEMP_B_W-1:0]    tmem [WINDOW_LEN];
    logic [scma_pkg::VDD_W-1:0]       vmem [WINDOW_LEN];
    logic [scma_pkg::TEMP_B_W-1:0]    t_rd_reg;
    logic [scma_pkg::VDD_W-1:0]       v_rd_reg;

    logic [scma_pkg::TEMP_B_W-1:0]    work_temp_reg;
    logic                             work_clip_reg;
    logic [scma_pkg::VDD_W-1:0]       vdd_reg;
    logic [TP_W-1:0]                  tprod_reg;
    logic [VP_W-1:0]                  vprod_reg;
    logic [scma_pkg::TEMP_B_W-1:0]    avg_tb_reg;
    logic [scma_pkg::VDD_W-1:0]       avg_v_reg;
    logic [CP_W-1:0]                  cprod_reg;
    scma_pkg::out_t                   result_reg;

    logic                             mem_rd;
    logic                             mem_wr;
    logic                             load_work;
    logic                             load_prod;
    logic                             load_avg;
    logic                             load_out;
    logic [scma_pkg::TEMP_B_W-1:0]    old_t;
    logic [scma_pkg::VDD_W-1:0]       old_v;
    logic [scma_pkg::VDD_W-1:0]       avg_v_c;
    logic [scma_pkg::TEMP_Q8_W-1:0]   temp_q8_c;
    logic [scma_pkg::RAIL_W:0]        rail3_c;
    scma_pkg::out_t                   res_c;
    scma_pkg::div_req_t               div_req;
    scma_pkg::div_resp_t              div_resp;

    scma_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    assign old_t   = valid_reg[slot_reg] ? t_rd_reg : scma_pkg::TEMP_BIAS;
    assign old_v   = valid_reg[slot_reg] ? v_rd_reg : '0;
    assign avg_v_c = vprod_reg[VK +: scma_pkg::VDD_W];

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        valid_next     = valid_reg;
        tsum_next      = tsum_reg;
        vsum_next      = vsum_reg;
        out_valid_next = out_valid_reg;
        fifo_pop       = 1'b0;
        mem_rd         = 1'b0;
        mem_wr         = 1'b0;
        load_work      = 1'b0;
        load_prod      = 1'b0;
        load_avg       = 1'b0;
        load_out       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = scma_pkg::VDD_NUM2 + scma_pkg::DIV_DW'(fifo_head.vref_code);
        div_req.divisor  = {fifo_head.vref_code, 1'b0};
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop      = 1'b1;
                    mem_rd        = 1'b1;
                    load_work     = 1'b1;
                    div_req.start = !fifo_head.clipped;
                    state_next    = fifo_head.clipped ? S_UPD : S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_resp.done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                mem_wr               = 1'b1;
                valid_next[slot_reg] = 1'b1;
                tsum_next  = tsum_reg + TS_W'(work_temp_reg) - TS_W'(old_t);
                vsum_next  = vsum_reg + VS_W'(vdd_reg) - VS_W'(old_v);
                slot_next  = (slot_reg == SW'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                load_prod  = 1'b1;
                state_next = S_SCL;
            end
            S_SCL:
            begin
                load_avg   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        temp_q8_c = {1'b0, avg_tb_reg} - scma_pkg::TEMP_Q8_W'(scma_pkg::TEMP_BIAS);
        rail3_c   = {1'b0, avg_v_reg, 1'b0} + (scma_pkg::RAIL_W + 1)'(avg_v_reg);
        res_c.avg_temp_q8    = $signed(temp_q8_c);
        res_c.avg_vdd_mv     = avg_v_reg;
        res_c.est_rail5_mv   = rail3_c[scma_pkg::RAIL_W:1];
        res_c.est_current_ma = scma_pkg::CUR_BASE_MA
                             + cprod_reg[scma_pkg::DIV10_SH +: scma_pkg::CUR_W];
        res_c.vdd_clipped    = work_clip_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            valid_reg     <= '0;
            tsum_reg      <= TSUM_RST;
            vsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            valid_reg     <= valid_next;
            tsum_reg      <= tsum_next;
            vsum_reg      <= vsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            tmem[slot_reg] <= work_temp_reg;
            vmem[slot_reg] <= vdd_reg;
        end
        if (mem_rd)
        begin
            t_rd_reg <= tmem[slot_reg];
            v_rd_reg <= vmem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_work)
        begin
            work_temp_reg <= fifo_head.temp_b;
            work_clip_reg <= fifo_head.clipped;
        end
        if (load_work && fifo_head.clipped)
        begin
            vdd_reg <= scma_pkg::VDD_MAX_MV;
        end
        else if ((state_reg == S_DIV) && div_resp.done)
        begin
            vdd_reg <= div_resp.quot;
        end
        if (load_prod)
        begin
            tprod_reg <= TP_W'(tsum_reg) * TP_W'(TM);
            vprod_reg <= VP_W'(vsum_reg) * VP_W'(VM);
        end
        if (load_avg)
        begin
            avg_tb_reg <= tprod_reg[TK +: scma_pkg::TEMP_B_W];
            avg_v_reg  <= avg_v_c;
            cprod_reg  <= CP_W'(avg_v_c) * CP_W'(scma_pkg::DIV10_M);
        end
        if (load_out)
        begin
            result_reg <= res_c;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SW'(WINDOW_LEN - 1))
        else $error("write slot beyond window");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_resp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_slot_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |=> valid_reg[$past(slot_reg)])
        else $error("updated slot not marked written");

    a_vsum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vsum_reg <= VSUM_MAX)
        else $error("supply running sum out of range");

endmodule

`default_nettype wire

>>> hw/rtl/sensor_code_convert_moving_average.sv
// Each input beat (temperature and reference codes) yields one result beat of windowed
// means over the last WINDOW_LEN items. An item leaves the queue, then waits in the divide
// state for twelve steps of the two-bit-per-cycle restoring divider, which turns the
// reference code into millivolts, and for the hand-over of the quotient; then follow the
// store update, the reciprocal multiply, the /10 scale and the output load, in that order;
// a saturating reference code (74 or less) skips the divide state and the divider. A result
// that waits to be popped holds the output load. The divider sets the rate. A two-entry
// queue and an input holding register let new beats in while the back end works or a
// result waits. The ring stores carry a written bit per entry, so no clearing pass follows
// reset.
// Depends on scma_pkg, scma_front, scma_fifo and scma_back.
`default_nettype none

module sensor_code_convert_moving_average #(
    parameter int unsigned WINDOW_LEN = scma_pkg::WINDOW_LEN_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire scma_pkg::in_t   sample,
    output logic                 empty,
    input  wire logic            pop,
    output scma_pkg::out_t       result
);

    logic              q_wr;
    logic              q_full;
    logic              q_rd;
    logic              q_empty;
    scma_pkg::q_item_t q_in;
    scma_pkg::q_item_t q_out;

    scma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .fifo_full (q_full),
        .wr_en     (q_wr),
        .item      (q_in)
    );

    scma_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_item (q_in),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_item (q_out),
        .empty   (q_empty)
    );

    scma_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (q_empty),
        .fifo_head  (q_out),
        .fifo_pop   (q_rd),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

`default_nettype wire
